### sv/msb_first_bit_packer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the MSB-first bit packer
// Clocked on clk; the first macro is disabled during reset, the second is not.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH

// property checked only while out of reset
`define BPK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bit packer assertion failed");

// property that also covers the reset cycles
`define BPK_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bit packer reset assertion failed");

`endif

### sv/bpk_pkg.sv
// ----------------------------------------------------------------------------
// bpk_pkg
// Types and constants shared by the bit packer modules.
// ----------------------------------------------------------------------------
package bpk_pkg;

  localparam int WordW  = 32;
  localparam int CountW = 6;
  localparam int QueueDepth = 2;
  localparam int PtrW   = $clog2(QueueDepth);
  localparam int CntW   = $clog2(QueueDepth + 1);

  localparam logic [CountW-1:0] WordBits = 6'd32;

  typedef enum logic [0:0] {
    OP_APPEND = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [WordW-1:0]  value;
    logic [CountW-1:0] count;
  } bpk_item_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } bpk_qstat_t;

  function automatic logic [WordW-1:0] low_mask(input logic [CountW-1:0] n);
    logic [WordW-1:0] m;
    if (n >= WordBits) begin
      m = {WordW{1'b1}};
    end else begin
      m = ({{(WordW-1){1'b0}}, 1'b1} << n[4:0]) - {{(WordW-1){1'b0}}, 1'b1};
    end
    return m;
  endfunction

endpackage

### sv/bpk_front.sv
// ----------------------------------------------------------------------------
// bpk_front
// Accepts input transactions, saturates the count, masks the code and drops
// zero-length appends before they reach the queue.
// ----------------------------------------------------------------------------
module bpk_front import bpk_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [WordW-1:0]  in_code_value,
  input  logic [CountW-1:0] in_bit_count,
  input  bpk_qstat_t        q_stat,
  output logic              q_push,
  output bpk_item_t         q_item
);

  logic [CountW-1:0] count_sat;
  op_t               op;

  always_comb begin
    op        = op_t'(in_mode);
    count_sat = (in_bit_count > WordBits) ? WordBits : in_bit_count;
    q_item.op    = op;
    q_item.count = count_sat;
    q_item.value = in_code_value & low_mask(count_sat);
  end

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full &&
                    !((op == OP_APPEND) && (count_sat == '0));

endmodule

### sv/bpk_queue.sv
// ----------------------------------------------------------------------------
// bpk_queue
// Two-entry queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module bpk_queue import bpk_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  bpk_item_t  push_item,
  input  logic       pop,
  output bpk_item_t  head_item,
  output bpk_qstat_t stat
);

  bpk_item_t       mem_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

  assign stat.full     = (cnt_r == CntFull);
  assign stat.nonempty = (cnt_r != '0);
  assign head_item     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### sv/bpk_back.sv
// ----------------------------------------------------------------------------
// bpk_back
// Packs queued transactions into the open word and registers completed words.
// ----------------------------------------------------------------------------
module bpk_back import bpk_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  bpk_qstat_t       q_stat,
  input  bpk_item_t        q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WordW-1:0] out_packed_word
);

  logic [WordW-1:0]  acc_r, acc_nxt;
  logic [CountW-1:0] free_r, free_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WordW-1:0]  word_r, word_nxt;

  logic [CountW-1:0] rest;
  logic [CountW-1:0] left;
  logic [WordW-1:0]  merged;
  logic              over;
  logic              emit;

  always_comb begin
    q_pop  = q_stat.nonempty && (!out_valid_r || !out_stall);
    over   = q_item.count > free_r;
    rest   = q_item.count - free_r;
    left   = free_r - q_item.count;
    merged = acc_r | (q_item.value << left);

    acc_nxt       = acc_r;
    free_nxt      = free_r;
    word_nxt      = word_r;
    emit          = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    if (q_pop) begin
      unique case (q_item.op)
        OP_FLUSH: begin
          if (free_r != WordBits) begin
            emit     = 1'b1;
            word_nxt = acc_r;
            acc_nxt  = '0;
            free_nxt = WordBits;
          end
        end
        OP_APPEND: begin
          if (over) begin
            emit     = 1'b1;
            word_nxt = acc_r | (q_item.value >> rest);
            acc_nxt  = q_item.value << (WordBits - rest);
            free_nxt = WordBits - rest;
          end else if (left == '0) begin
            emit     = 1'b1;
            word_nxt = merged;
            acc_nxt  = '0;
            free_nxt = WordBits;
          end else begin
            acc_nxt  = merged;
            free_nxt = left;
          end
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      free_r      <= WordBits;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_packed_word = word_r;

endmodule

### sv/msb_first_bit_packer_core.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer_core
// Takes one transaction per clock while in_stall is low; a completed word goes
// through a queue entry and then the result register to the output. The front
// saturates and masks each code, a two-entry queue holds it, and the back
// shifts it into the open word with one shift-and-OR per cycle, so the rate is
// one transaction per cycle while the result register drains. in_stall rises
// only after out_stall has held the result register and filled the queue.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_core import bpk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [WordW-1:0]  in_code_value,
  input  logic [CountW-1:0] in_bit_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WordW-1:0]  out_packed_word
);

  bpk_qstat_t q_stat;
  bpk_item_t  push_item;
  bpk_item_t  head_item;
  logic       q_push;
  logic       q_pop;

  bpk_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_code_value (in_code_value),
    .in_bit_count  (in_bit_count),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  bpk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  bpk_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packed_word (out_packed_word)
  );

endmodule

### sv/bpk_checker.sv
// ----------------------------------------------------------------------------
// bpk_checker
// Port-level checks for the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "msb_first_bit_packer_core_assert.svh"

module bpk_checker import bpk_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [WordW-1:0] out_packed_word
);

  `BPK_ASSERT(a_out_valid_held, out_valid && out_stall |=> out_valid)
  `BPK_ASSERT(a_out_word_held, out_valid && out_stall |=> $stable(out_packed_word))
  `BPK_ASSERT_RST(a_reset_clears, !rst_n |=> !out_valid && !in_stall)
  `BPK_ASSERT(a_stall_from_back, $rose(in_stall) |-> $past(out_stall))

endmodule

bind msb_first_bit_packer_core bpk_checker u_bpk_checker (.*);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives msb_first_bit_packer_core with codes and flushes under random valid
// gaps and output stalls. A word tracker predicts every packed word from the
// accepted transactions and checks each output transaction against it in order.
// ----------------------------------------------------------------------------
module testbench;
  import bpk_pkg::*;

  localparam int RandomCodes = 400;
  localparam int CycleLimit  = 200000;

  class word_tracker;
    logic [WordW-1:0] open_word;
    int unsigned      room;
    logic [WordW-1:0] words_due[$];
    int               mismatches;
    int               codes_seen;
    int               flushes_seen;
    int               words_checked;

    function new();
      open_word     = '0;
      room          = 32;
      mismatches    = 0;
      codes_seen    = 0;
      flushes_seen  = 0;
      words_checked = 0;
    endfunction

    function automatic logic [63:0] mask_of(int unsigned n);
      return (64'd1 << n) - 64'd1;
    endfunction

    function void take_code(op_t op, logic [WordW-1:0] value, logic [CountW-1:0] count);
      int unsigned n;
      int unsigned rest;
      logic [63:0] bits;
      if (op == OP_FLUSH) begin
        flushes_seen++;
        if (room != 32) begin
          words_due.push_back(open_word);
          open_word = '0;
          room      = 32;
        end
        return;
      end
      codes_seen++;
      n    = (count > 32) ? 32 : count;
      bits = {32'd0, value} & mask_of(n);
      if (n > room) begin
        rest = n - room;
        words_due.push_back(open_word | WordW'(bits >> rest));
        open_word = WordW'((bits & mask_of(rest)) << (32 - rest));
        room      = 32 - rest;
      end else begin
        open_word = open_word | WordW'(bits << (room - n));
        room      = room - n;
        if (room == 0) begin
          words_due.push_back(open_word);
          open_word = '0;
          room      = 32;
        end
      end
    endfunction

    function void check_word(logic [WordW-1:0] actual);
      logic [WordW-1:0] due;
      if (words_due.size() == 0) begin
        $display("%0t: unexpected packed word: expected none, actual %h", $time, actual);
        mismatches++;
        return;
      end
      due = words_due.pop_front();
      words_checked++;
      if (actual !== due) begin
        $display("%0t: packed word mismatch: expected %h, actual %h", $time, due, actual);
        mismatches++;
      end
    endfunction

    function int pending();
      return words_due.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_mode = 1'b0;
  logic [WordW-1:0]  in_code_value = '0;
  logic [CountW-1:0] in_bit_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WordW-1:0]  out_packed_word;

  word_tracker tracker;
  bit          steady = 1'b0;
  int          cycle_count = 0;

  msb_first_bit_packer_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_code_value   (in_code_value),
    .in_bit_count    (in_bit_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packed_word (out_packed_word)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tracker.take_code(op_t'(in_mode), in_code_value, in_bit_count);
      end
      if (out_valid && !out_stall) begin
        tracker.check_word(out_packed_word);
      end
    end
  end

  task automatic send_code(op_t op, logic [WordW-1:0] value, logic [CountW-1:0] count);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid      <= 1'b0;
      in_code_value <= $urandom;
      in_bit_count  <= CountW'($urandom);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_mode       <= op;
    in_code_value <= value;
    in_bit_count  <= count;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_code();
    int pick;
    logic [WordW-1:0]  value;
    logic [CountW-1:0] count;
    pick  = $urandom_range(0, 99);
    value = $urandom;
    if ($urandom_range(0, 9) == 0) value = $urandom_range(0, 1) ? '1 : '0;
    if (pick < 8) begin
      send_code(OP_FLUSH, value, CountW'($urandom));
    end else begin
      if (pick < 12)      count = '0;
      else if (pick < 17) count = CountW'($urandom_range(33, 63));
      else if (pick < 22) count = 6'd32;
      else                count = CountW'($urandom_range(1, 31));
      send_code(OP_APPEND, value, count);
    end
  endtask

  initial begin
    tracker = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    send_code(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
    send_code(OP_FLUSH,  32'h0000_0000, 6'd0);
    send_code(OP_APPEND, 32'hFFFF_FFFF, 6'd32);
    send_code(OP_APPEND, 32'h0000_0000, 6'd32);
    send_code(OP_APPEND, 32'hA5A5_A5A5, 6'd63);
    send_code(OP_APPEND, 32'h5A5A_5A5A, 6'd33);
    send_code(OP_APPEND, 32'hFFFF_FFFF, 6'd1);
    send_code(OP_APPEND, 32'h8000_0001, 6'd32);
    send_code(OP_APPEND, 32'hFFFF_FFE5, 6'd5);
    send_code(OP_FLUSH,  32'hDEAD_BEEF, 6'd40);
    send_code(OP_FLUSH,  32'hFFFF_FFFF, 6'd63);
    send_code(OP_APPEND, 32'h1234_ABCD, 6'd16);
    send_code(OP_APPEND, 32'hFFFF_4321, 6'd16);
    send_code(OP_APPEND, 32'hFFFF_FF7F, 6'd7);
    send_code(OP_APPEND, 32'hFFFF_FFFF, 6'd31);
    send_code(OP_FLUSH,  32'h0000_0000, 6'd0);
    send_code(OP_APPEND, 32'hFFFF_FFFE, 6'd1);
    send_code(OP_FLUSH,  32'hFFFF_FFFF, 6'd32);
    send_code(OP_APPEND, 32'h7FFF_FFFF, 6'd31);
    send_code(OP_APPEND, 32'h0000_0001, 6'd1);
    send_code(OP_APPEND, 32'h0000_0003, 6'd2);
    send_code(OP_APPEND, 32'hFFFF_FFFF, 6'd62);
    send_code(OP_FLUSH,  32'h0000_0000, 6'd0);
    drain_words();

    for (int i = 0; i < RandomCodes; i++) begin
      steady = (i >= 250 && i < 330);
      if (i == 200) drain_words();
      send_random_code();
    end
    steady = 1'b0;
    send_code(OP_FLUSH, 32'h0000_0000, 6'd0);

    drain_words();
    repeat (16) @(posedge clk);

    $display("Sent %0d appends and %0d flushes; checked %0d packed words.",
             tracker.codes_seen, tracker.flushes_seen, tracker.words_checked);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
